// ===== design/msie_pkg.sv =====
// Shared types, instruction codes and helpers for the MIPS subset executor.
package msie_pkg;

    localparam int DATA_WORDS_DEF = 1024;
    localparam int RF_DEPTH       = 32;
    localparam int RF_AW          = 5;
    localparam int XLEN           = 32;

    localparam logic [5:0] OP_RTYPE = 6'b000000;
    localparam logic [5:0] OP_ADDI  = 6'b001000;
    localparam logic [5:0] OP_BEQ   = 6'b000100;
    localparam logic [5:0] OP_LW    = 6'b100011;
    localparam logic [5:0] OP_SW    = 6'b101011;
    localparam logic [5:0] OP_J     = 6'b000010;

    localparam logic [5:0] FN_ADD = 6'b100000;
    localparam logic [5:0] FN_SUB = 6'b100010;
    localparam logic [5:0] FN_AND = 6'b100100;
    localparam logic [5:0] FN_OR  = 6'b100101;
    localparam logic [5:0] FN_SLT = 6'b101010;

    // Register file read request: two source addresses sampled together.
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] ra;
        logic [RF_AW-1:0] rb;
    } rf_rd_t;

    // Register file write port.
    typedef struct packed {
        logic             en;
        logic [RF_AW-1:0] addr;
        logic [XLEN-1:0]  data;
    } rf_wr_t;

    function automatic logic [XLEN-1:0] sext16(input logic [15:0] v);
        return {{(XLEN-16){v[15]}}, v};
    endfunction

endpackage

// ===== design/mips_subset_instruction_executor.sv =====
// Top level of the MIPS subset executor: pipeline control, data store and output register.
//
// Executes add, sub, and, or, slt, addi, beq, lw, sw and j, one instruction per request,
// against a 32-entry register file, an instruction-index program counter and a data store of
// DATA_WORDS words. The register file and data store memories are read on the edge that
// accepts a request. The instruction executes in the next cycle and waits there while the
// output register holds an untaken result. When it advances, it writes back the register
// file, the data store and the program counter, and its result moves into the output
// register, raising out_valid. A new request is accepted every cycle while results are
// taken, so the sustained rate is one instruction per clock; write bypass on both memories
// covers a dependent instruction that directly follows. After reset the data store is
// cleared one word a cycle, and in_ready stays low until the whole store is cleared.
// lw and sw address the store by imm16 >> 2, ignoring the base register; an address past the
// store reads zero and stores nothing. Unknown opcodes or functs change nothing and report
// illegal with next_pc equal to the current program counter.
module mips_subset_instruction_executor #(
    parameter int DATA_WORDS = msie_pkg::DATA_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         instruction,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  next_pc,
    output logic                reg_written,
    output logic [4:0]          dest_reg,
    output logic signed [31:0]  dest_value,
    output logic                mem_written,
    output logic                illegal
);
    import msie_pkg::*;

    localparam int AW = $clog2(DATA_WORDS);

    // Pipeline control
    logic            in_fire;
    logic            s1_fire;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic [31:0]     s1_ins_reg;
    logic            out_valid_reg;
    logic            out_valid_next;

    // Architectural state outside the memories
    logic [XLEN-1:0] pc_reg;
    logic [XLEN-1:0] pc_next;

    // Clearing pass over the data store
    logic            clr_active_reg;
    logic            clr_active_next;
    logic [AW-1:0]   clr_idx_reg;
    logic [AW-1:0]   clr_idx_next;

    // Data store
    logic [XLEN-1:0] ds_mem [DATA_WORDS];
    logic [XLEN-1:0] ds_q_reg;
    logic            ds_byp_en_reg;
    logic [AW-1:0]   ds_byp_addr_reg;
    logic [XLEN-1:0] ds_byp_data_reg;
    logic            ds_we;
    logic [AW-1:0]   ds_waddr;
    logic [XLEN-1:0] ds_wdata;
    logic [AW-1:0]   ds_raddr;
    logic [XLEN-1:0] ds_rdata;

    // Register file
    rf_rd_t          rf_rd;
    rf_wr_t          rf_wr;
    logic [XLEN-1:0] a_val;
    logic [XLEN-1:0] b_val;

    // Decode and execute of the instruction in the second stage
    logic [5:0]      ex_op;
    logic [5:0]      ex_fn;
    logic [4:0]      ex_rt;
    logic [4:0]      ex_rd;
    logic [15:0]     ex_imm;
    logic [13:0]     ex_idx;
    logic            ex_in_range;
    logic            ex_wr;
    logic            ex_mw;
    logic            ex_bad;
    logic [4:0]      ex_dreg;
    logic [XLEN-1:0] ex_dval;
    logic [XLEN-1:0] ex_npc;

    // Output register payload
    logic [XLEN-1:0] npc_out_reg;
    logic            wr_out_reg;
    logic [4:0]      dreg_out_reg;
    logic [XLEN-1:0] dval_out_reg;
    logic            mw_out_reg;
    logic            bad_out_reg;

    // Handshake: the second stage advances when the output register is free or drains.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_fire ? 1'b1 : ((out_valid_reg && out_ready) ? 1'b0
                                                                             : out_valid_reg);

    // Clearing pass: sweep the whole store once after reset.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(DATA_WORDS - 1))
                clr_active_next = 1'b0;
        end
    end

    // Read requests are issued at acceptance.
    assign rf_rd.en = in_fire;
    assign rf_rd.ra = instruction[25:21];
    assign rf_rd.rb = instruction[20:16];
    assign ds_raddr = instruction[2 +: AW];

    msie_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd     (rf_rd),
        .wr     (rf_wr),
        .a_data (a_val),
        .b_data (b_val)
    );

    // Field extraction for the executing instruction
    assign ex_op       = s1_ins_reg[31:26];
    assign ex_fn       = s1_ins_reg[5:0];
    assign ex_rt       = s1_ins_reg[20:16];
    assign ex_rd       = s1_ins_reg[15:11];
    assign ex_imm      = s1_ins_reg[15:0];
    assign ex_idx      = ex_imm[15:2];
    assign ex_in_range = (32'(ex_idx) < 32'(DATA_WORDS));

    // Load data, with a store from the same edge as the read forwarded.
    assign ds_rdata = (ds_byp_en_reg && (ds_byp_addr_reg == ex_idx[AW-1:0]))
                      ? ds_byp_data_reg : ds_q_reg;

    // Execute
    always_comb
    begin
        ex_wr   = 1'b0;
        ex_mw   = 1'b0;
        ex_bad  = 1'b0;
        ex_dreg = '0;
        ex_dval = '0;
        ex_npc  = pc_reg + 32'd1;
        case (ex_op)
            OP_RTYPE:
            begin
                ex_wr   = 1'b1;
                ex_dreg = ex_rd;
                case (ex_fn)
                    FN_ADD:  ex_dval = a_val + b_val;
                    FN_SUB:  ex_dval = a_val - b_val;
                    FN_AND:  ex_dval = a_val & b_val;
                    FN_OR:   ex_dval = a_val | b_val;
                    FN_SLT:  ex_dval = ($signed(a_val) < $signed(b_val)) ? 32'd1 : 32'd0;
                    default: ex_bad  = 1'b1;
                endcase
            end
            OP_ADDI:
            begin
                ex_wr   = 1'b1;
                ex_dreg = ex_rt;
                ex_dval = a_val + sext16(ex_imm);
            end
            OP_BEQ:
            begin
                if (a_val == b_val)
                    ex_npc = sext16(ex_imm);
            end
            OP_LW:
            begin
                ex_wr   = 1'b1;
                ex_dreg = ex_rt;
                ex_dval = ex_in_range ? ds_rdata : '0;
            end
            OP_SW:
            begin
                ex_mw = ex_in_range;
            end
            OP_J:
            begin
                ex_npc = {6'b0, s1_ins_reg[25:0]};
            end
            default:
            begin
                ex_bad = 1'b1;
            end
        endcase
        // Drop every effect of an unsupported instruction.
        if (ex_bad)
        begin
            ex_wr   = 1'b0;
            ex_mw   = 1'b0;
            ex_dreg = '0;
            ex_dval = '0;
            ex_npc  = pc_reg;
        end
    end

    assign pc_next = s1_fire ? ex_npc : pc_reg;

    // Write-back ports
    assign rf_wr.en   = s1_fire && ex_wr;
    assign rf_wr.addr = ex_dreg;
    assign rf_wr.data = ex_dval;

    assign ds_we    = clr_active_reg || (s1_fire && ex_mw);
    assign ds_waddr = clr_active_reg ? clr_idx_reg : ex_idx[AW-1:0];
    assign ds_wdata = clr_active_reg ? '0 : b_val;

    // Data store memory: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (ds_we)
        begin
            ds_mem[ds_waddr] <= ds_wdata;
        end
        if (in_fire)
        begin
            ds_q_reg        <= ds_mem[ds_raddr];
            ds_byp_addr_reg <= ds_waddr;
            ds_byp_data_reg <= ds_wdata;
        end
    end

    // Payload registers: hold unless loaded.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ins_reg <= instruction;
        end
        if (s1_fire)
        begin
            npc_out_reg  <= ex_npc;
            wr_out_reg   <= ex_wr;
            dreg_out_reg <= ex_dreg;
            dval_out_reg <= ex_dval;
            mw_out_reg   <= ex_mw;
            bad_out_reg  <= ex_bad;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pc_reg         <= '0;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            ds_byp_en_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            pc_reg         <= pc_next;
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            if (in_fire)
            begin
                ds_byp_en_reg <= ds_we;
            end
        end
    end

    // Outputs
    assign out_valid   = out_valid_reg;
    assign next_pc     = $signed(npc_out_reg);
    assign reg_written = wr_out_reg;
    assign dest_reg    = dreg_out_reg;
    assign dest_value  = $signed(dval_out_reg);
    assign mem_written = mw_out_reg;
    assign illegal     = bad_out_reg;

endmodule

// ===== design/msie_regfile.sv =====
// 32 x 32 register file: synchronous two-read memory with valid bits and write bypass.
module msie_regfile (
    input  logic                              clk,
    input  logic                              rst_n,
    input  msie_pkg::rf_rd_t                  rd,
    input  msie_pkg::rf_wr_t                  wr,
    output logic [msie_pkg::XLEN-1:0]         a_data,
    output logic [msie_pkg::XLEN-1:0]         b_data
);
    import msie_pkg::*;

    logic [XLEN-1:0]     mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] vld_reg;
    logic [XLEN-1:0]     qa_reg;
    logic [XLEN-1:0]     qb_reg;
    logic                va_reg;
    logic                vb_reg;
    logic [RF_AW-1:0]    ra_reg;
    logic [RF_AW-1:0]    rb_reg;
    logic                byp_en_reg;
    logic [RF_AW-1:0]    byp_addr_reg;
    logic [XLEN-1:0]     byp_data_reg;

    // Storage and read port; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            qa_reg       <= mem[rd.ra];
            qb_reg       <= mem[rd.rb];
            ra_reg       <= rd.ra;
            rb_reg       <= rd.rb;
            byp_addr_reg <= wr.addr;
            byp_data_reg <= wr.data;
        end
    end

    // Valid bits: an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            byp_en_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                va_reg     <= vld_reg[rd.ra];
                vb_reg     <= vld_reg[rd.rb];
                byp_en_reg <= wr.en;
            end
        end
    end

    // Forward a write that landed on the same edge as the read.
    always_comb
    begin
        if (byp_en_reg && (byp_addr_reg == ra_reg))
            a_data = byp_data_reg;
        else
            a_data = va_reg ? qa_reg : '0;
        if (byp_en_reg && (byp_addr_reg == rb_reg))
            b_data = byp_data_reg;
        else
            b_data = vb_reg ? qb_reg : '0;
    end

endmodule
